// File: sv/lspq_pkg.sv
package lspq_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int OCC_W = 5;

	typedef enum logic [1:0] {
		OP_ENQ  = 2'd0,
		OP_DEQ  = 2'd1,
		OP_PEEK = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT
	} state_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] prio;
		logic [63:0]        payload;
	} cmd_t;

	typedef struct packed {
		logic               found;
		logic [63:0]        out_payload;
		logic signed [31:0] out_prio;
		logic               overflow;
		logic [OCC_W-1:0]   occupancy;
	} result_t;

	typedef struct packed {
		logic signed [31:0] prio;
		logic [63:0]        payload;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: sv/lspq_ram.sv
module lspq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/lspq_cmp.sv
module lspq_cmp (
	input  lspq_pkg::entry_t a,
	input  lspq_pkg::entry_t b,
	output logic             a_better
);
	import lspq_pkg::*;

	// Higher priority wins; on equal priority the smaller value wins.
	always_comb begin
		if (a.prio != b.prio) begin
			a_better = (a.prio > b.prio);
		end else begin
			a_better = (a.payload < b.payload);
		end
	end

endmodule

// File: sv/linear_scan_priority_queue.sv
// Enqueue, an unknown kind, and peek or dequeue on an empty table: done in the cycle after start.
// Peek: scans the table, one table entry read per cycle through the compare unit, then shows done.
// Dequeue: the same scan, then a shift that moves each entry behind the removed one down one place.
// One word per op; busy stays high for the scan and shift, ready again as done shows.
// Results are shown for one cycle on done; the receiver cannot stall.
// Reset (arst_n low) empties the queue and idles the sequencer; table memory is not cleared.
module linear_scan_priority_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  lspq_pkg::cmd_t    cmd,
	output logic              done,
	output lspq_pkg::result_t result
);
	import lspq_pkg::*;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [IDX_W-1:0]  scan_idx_q, scan_idx_d;
	logic [IDX_W-1:0]  best_idx_q, best_idx_d;
	logic [IDX_W-1:0]  sh_q, sh_d;
	entry_t            best_q, best_d;
	logic              deq_q, deq_d;
	logic              done_q, done_d;
	result_t           result_q, result_d;

	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	entry_t            ram_wdata;
	logic [IDX_W-1:0]  ram_raddr;
	entry_t            ram_rdata;

	logic              rd_better;
	logic              take;
	entry_t            best_n;
	logic [IDX_W-1:0]  best_idx_n;

	lspq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	lspq_cmp u_cmp (
		.a       (ram_rdata),
		.b       (best_q),
		.a_better(rd_better)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		scan_idx_q <= scan_idx_d;
		best_idx_q <= best_idx_d;
		sh_q       <= sh_d;
		best_q     <= best_d;
		deq_q      <= deq_d;
		result_q   <= result_d;
	end

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		scan_idx_d = scan_idx_q;
		best_idx_d = best_idx_q;
		sh_d       = sh_q;
		best_d     = best_q;
		deq_d      = deq_q;
		done_d     = 1'b0;
		result_d   = result_q;

		ram_we     = 1'b0;
		ram_waddr  = count_q[IDX_W-1:0];
		ram_wdata  = '{prio: cmd.prio, payload: cmd.payload};
		ram_raddr  = '0;

		// The first entry read always seeds the running best.
		take       = (scan_idx_q == '0) || rd_better;
		best_n     = take ? ram_rdata : best_q;
		best_idx_n = take ? scan_idx_q : best_idx_q;

		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					result_d = '0;
					priority case (1'b1)
						(cmd.kind == OP_ENQ): begin
							if (count_q >= CNT_W'(CAPACITY)) begin
								result_d.overflow = 1'b1;
							end else begin
								ram_we  = 1'b1;
								count_d = count_q + CNT_W'(1);
							end
							done_d = 1'b1;
						end
						((cmd.kind == OP_DEQ) || (cmd.kind == OP_PEEK)): begin
							if (count_q == '0) begin
								done_d = 1'b1;
							end else begin
								deq_d      = (cmd.kind == OP_DEQ);
								scan_idx_d = '0;
								state_d    = ST_SCAN;
							end
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
					result_d.occupancy = OCC_W'(count_d);
				end
			end

			ST_SCAN: begin
				best_d     = best_n;
				best_idx_d = best_idx_n;
				scan_idx_d = scan_idx_q + IDX_W'(1);
				ram_raddr  = scan_idx_q + IDX_W'(1);
				if (CNT_W'(scan_idx_q) + CNT_W'(1) == count_q) begin
					result_d.found       = 1'b1;
					result_d.out_payload = best_n.payload;
					result_d.out_prio    = best_n.prio;
					result_d.overflow    = 1'b0;
					if (!deq_q) begin
						result_d.occupancy = OCC_W'(count_q);
						done_d  = 1'b1;
						state_d = ST_IDLE;
					end else if (CNT_W'(best_idx_n) + CNT_W'(1) < count_q) begin
						// Later entries move down one place, starting behind the winner.
						ram_raddr = best_idx_n + IDX_W'(1);
						sh_d      = best_idx_n;
						state_d   = ST_SHIFT;
					end else begin
						count_d            = count_q - CNT_W'(1);
						result_d.occupancy = OCC_W'(count_d);
						done_d             = 1'b1;
						state_d            = ST_IDLE;
					end
				end
			end

			ST_SHIFT: begin
				ram_we    = 1'b1;
				ram_waddr = sh_q;
				ram_wdata = ram_rdata;
				ram_raddr = sh_q + IDX_W'(2);
				sh_d      = sh_q + IDX_W'(1);
				if (CNT_W'(sh_q) + CNT_W'(2) == count_q) begin
					count_d            = count_q - CNT_W'(1);
					result_d.occupancy = OCC_W'(count_d);
					done_d             = 1'b1;
					state_d            = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

// File: sv/lspq_checker.sv
module lspq_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input lspq_pkg::result_t result
);
	import lspq_pkg::*;

	// An accepted word either finishes next cycle or holds the block busy.
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted word neither busy nor done");

	a_busy_ends_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy fell without a result");

	a_found_xor_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.found && result.overflow))
		else $error("found and overflow together");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.found |-> (result.out_payload == '0) && (result.out_prio == '0))
		else $error("nonzero entry data without found");

	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.occupancy <= OCC_W'(CAPACITY)))
		else $error("occupancy beyond capacity");

endmodule

bind linear_scan_priority_queue lspq_checker u_lspq_checker (.*);

// File: bench/lspq_tb_pkg.sv
package lspq_tb_pkg;
	import lspq_pkg::*;

	// The kind code that the block leaves unassigned.
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	class queue_scoreboard;
		logic signed [31:0] slot_prio [CAPACITY];
		logic [63:0]        slot_payload [CAPACITY];
		int                 fill;
		result_t            awaited [$];
		int                 errors;
		int                 shown;
		int                 words;
		int                 enqueued;
		int                 dropped;
		int                 removed;
		int                 peeked;
		int                 empty_hits;
		int                 unused_hits;
		int                 peak_fill;

		function new();
			fill = 0;
			errors = 0;
			shown = 0;
			words = 0;
			enqueued = 0;
			dropped = 0;
			removed = 0;
			peeked = 0;
			empty_hits = 0;
			unused_hits = 0;
			peak_fill = 0;
		endfunction

		task report(string msg);
			errors++;
			if (shown < 40) begin
				shown++;
				$display("error: %s", msg);
			end
		endtask

		// Highest priority wins; on equal priority the smaller value, then the lower slot.
		function int best_slot();
			int b;
			b = 0;
			for (int i = 1; i < fill; i++) begin
				if (slot_prio[i] > slot_prio[b] ||
				    (slot_prio[i] == slot_prio[b] && slot_payload[i] < slot_payload[b]))
					b = i;
			end
			return b;
		endfunction

		task note(cmd_t c);
			result_t r;
			int      b;
			r = '0;
			words++;
			if (c.kind == OP_ENQ) begin
				if (fill >= CAPACITY) begin
					r.overflow = 1'b1;
					dropped++;
				end else begin
					slot_prio[fill] = c.prio;
					slot_payload[fill] = c.payload;
					fill++;
					enqueued++;
				end
			end else if ((c.kind == OP_DEQ || c.kind == OP_PEEK) && fill > 0) begin
				b = best_slot();
				r.found = 1'b1;
				r.out_payload = slot_payload[b];
				r.out_prio = slot_prio[b];
				if (c.kind == OP_DEQ) begin
					for (int i = b; i + 1 < fill; i++) begin
						slot_prio[i] = slot_prio[i + 1];
						slot_payload[i] = slot_payload[i + 1];
					end
					fill--;
					removed++;
				end else begin
					peeked++;
				end
			end else if (c.kind == KIND_UNUSED) begin
				unused_hits++;
			end else begin
				empty_hits++;
			end
			r.occupancy = OCC_W'(fill);
			if (fill > peak_fill)
				peak_fill = fill;
			awaited.push_back(r);
		endtask

		task check(result_t got);
			result_t want;
			if (awaited.size() == 0) begin
				report($sformatf("result with nothing pending: %p", got));
				return;
			end
			want = awaited.pop_front();
			if (got.found !== want.found)
				report($sformatf("found got %0b want %0b", got.found, want.found));
			if (got.out_payload !== want.out_payload)
				report($sformatf("out_payload got %h want %h", got.out_payload, want.out_payload));
			if (got.out_prio !== want.out_prio)
				report($sformatf("out_prio got %0d want %0d", got.out_prio, want.out_prio));
			if (got.overflow !== want.overflow)
				report($sformatf("overflow got %0b want %0b", got.overflow, want.overflow));
			if (got.occupancy !== want.occupancy)
				report($sformatf("occupancy got %0d want %0d", got.occupancy, want.occupancy));
		endtask
	endclass

endpackage

// File: bench/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lspq_pkg::*;
	import lspq_tb_pkg::*;

	localparam logic signed [31:0] PRIO_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] PRIO_MIN = 32'sh80000000;
	localparam int RANDOM_WORDS = 1400;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	logic    busy;
	cmd_t    cmd = '0;
	logic    done;
	result_t result;

	queue_scoreboard board;

	always #5 clk = ~clk;

	linear_scan_priority_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			board.check(result);
	end

	// Mostly short gaps, now and then a long one.
	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [31:0] rand_prio();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30) begin
			case ($urandom_range(0, 4))
				0: return PRIO_MIN;
				1: return -32'sd1;
				2: return 32'sd0;
				3: return 32'sd1;
				default: return PRIO_MAX;
			endcase
		end
		// A narrow range makes equal priorities common, so the value decides.
		if (r < 60)
			return $signed($urandom_range(0, 6)) - 3;
		return $urandom;
	endfunction

	function automatic logic [63:0] rand_payload();
		int          r;
		int          len;
		logic [63:0] v;
		r = $urandom_range(0, 99);
		v = '0;
		if (r < 25) begin
			case ($urandom_range(0, 3))
				0: v = '0;
				1: v = 64'd1;
				2: v = '1;
				default: v = 64'h4100_0000_0000_0000;
			endcase
		end else if (r < 50) begin
			len = $urandom_range(1, 8);
			for (int i = 0; i < len; i++)
				v[63 - 8 * i -: 8] = 8'($urandom_range(32, 126));
		end else begin
			v = {$urandom, $urandom};
		end
		return v;
	endfunction

	// Mode 0 leans toward filling the table, 1 toward draining it, 2 is balanced.
	function automatic logic [1:0] pick_kind(int mode);
		int r;
		r = $urandom_range(0, 99);
		case (mode)
			0: begin
				if (r < 60) return OP_ENQ;
				if (r < 75) return OP_DEQ;
				if (r < 95) return OP_PEEK;
			end
			1: begin
				if (r < 20) return OP_ENQ;
				if (r < 75) return OP_DEQ;
				if (r < 95) return OP_PEEK;
			end
			default: begin
				if (r < 40) return OP_ENQ;
				if (r < 70) return OP_DEQ;
				if (r < 96) return OP_PEEK;
			end
		endcase
		return KIND_UNUSED;
	endfunction

	// Holds start high until the word is taken, then idles for the given gap.
	task automatic send_word(logic [1:0] kind, logic signed [31:0] prio,
	                         logic [63:0] payload, int gap);
		cmd_t c;
		c.kind = kind;
		c.prio = prio;
		c.payload = payload;
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy !== 1'b0);
		board.note(c);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		logic signed [31:0] fill_prio [16];
		logic [63:0]        fill_payload [16];
		int                 mode;
		int                 quiet;
		int                 sent;
		logic [1:0]         k;

		board = new();
		fill_prio = '{32'sd0, PRIO_MAX, PRIO_MIN, PRIO_MAX, PRIO_MAX, PRIO_MAX,
		              -32'sd1, 32'sd1, PRIO_MIN, 32'sd0, 32'sd0, -32'sd1,
		              32'sh5a5a5a5a, 32'sha5a5a5a5, 32'sd1, PRIO_MAX};
		fill_payload = '{64'h4100_0000_0000_0000, 64'd0, '1, 64'd5, 64'd5, 64'd3,
		                 64'h4200_0000_0000_0000, 64'h4142_0000_0000_0000, 64'd0,
		                 64'h4141_4141_4141_4141, 64'h4141_4141_4141_4140, '1,
		                 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa,
		                 64'h4142_0000_0000_0000, 64'd3};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table: peek, dequeue and the unused kind all leave it unchanged.
		send_word(OP_PEEK, PRIO_MAX, '1, rand_gap());
		send_word(OP_DEQ, PRIO_MIN, '1, rand_gap());
		send_word(KIND_UNUSED, PRIO_MAX, '1, rand_gap());
		// Fill to capacity with extreme keys, duplicates and value ties.
		for (int i = 0; i < 16; i++)
			send_word(OP_ENQ, fill_prio[i], fill_payload[i], rand_gap());
		// Full table: this word is dropped and flagged.
		send_word(OP_ENQ, PRIO_MAX, 64'd1, rand_gap());
		send_word(KIND_UNUSED, 32'sd0, '0, rand_gap());
		send_word(OP_PEEK, 32'sd0, '0, rand_gap());
		repeat (3)
			send_word(OP_DEQ, 32'sd0, '0, rand_gap());

		sent = 0;
		mode = 0;
		quiet = 0;
		while (sent < RANDOM_WORDS) begin
			if (sent % 48 == 0) begin
				mode = $urandom_range(0, 2);
				quiet = ($urandom_range(0, 3) == 0);
			end
			k = pick_kind(mode);
			send_word(k, rand_prio(), rand_payload(), quiet ? 0 : rand_gap());
			if (k != KIND_UNUSED)
				sent++;
		end
		start <= 1'b0;

		while (board.awaited.size() != 0)
			@(posedge clk);
		repeat (2 * CAPACITY + 8) @(posedge clk);

		$display("covered %0d words: %0d stored, %0d dropped on a full table, %0d removed,",
		         board.words, board.enqueued, board.dropped, board.removed);
		$display("%0d peeks, %0d on an empty table, %0d of the unused kind, peak occupancy %0d",
		         board.peeked, board.empty_hits, board.unused_hits, board.peak_fill);
		if (board.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#(10_000_000);
		$display("timeout waiting for the queue");
		$display("end of test: mismatches");
		$finish;
	end

endmodule
